@@ design/sfdc_pkg.sv @@
// Shared constants for the serial frame deframer with CRC-32 check.
package sfdc_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'h7E;
    localparam logic [7:0]  SYNC_SECOND  = 8'h77;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Number of CRC bytes that close a frame
    localparam int unsigned CRC_BYTES    = 4;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_GOOD    = 2'd1;
    localparam kind_t KIND_BAD     = 2'd2;

endpackage

@@ design/sfdc_crc8.sv @@
// Byte-wide update of the reflected CRC-32, unrolled over eight bit steps.
module sfdc_crc8 (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import sfdc_pkg::*;

    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        crc_out = c;
    end

endmodule

@@ design/serial_frame_deframer_crc32.sv @@
// Top level: byte stream deframer with sync hunt, payload pass-through and CRC-32 check.
//
//  Channel | Dir | Transfer content
//  --------+-----+-----------------------------------------------------------------
//  s_      | in  | tdata[7:0] rx_byte
//  m_      | out | tuser[1:0] result_kind; tdata: byte_value, byte_index,
//          |     |   frame_command, frame_length (bits 7:0 up to 31:24)
//
// One byte per cycle sustained while m_tready does not stall the result register. A
// byte is held in the input register, then the parser and the byte-wide CRC update
// run combinationally into the result register, loaded as the parser advances.
// aresetn (synchronous, active low) returns the parser to the sync hunt.
// A stalled result holds the input register; s_tready stays high while the
// result register drains in the same cycle.
module serial_frame_deframer_crc32 (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] byte_value, [15:8] byte_index,
                                   // [23:16] frame_command, [31:24] frame_length
    output sfdc_pkg::kind_t m_tuser // [1:0] result_kind
);
    import sfdc_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRC   = 3'd5;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  length_reg,  length_next;
    logic [7:0]  count_reg,   count_next;
    logic [31:0] crc_reg,     crc_next;
    logic [23:0] rx_crc_reg,  rx_crc_next;   // holds the first three CRC bytes; the fourth joins them at the check

    // result register
    logic        out_valid_reg;
    kind_t       out_kind_reg,  out_kind_next;
    logic [7:0]  out_value_reg, out_value_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic [7:0]  out_cmd_reg,   out_cmd_next;
    logic [7:0]  out_len_reg,   out_len_next;
    logic        emit;

    logic        advance;
    logic [7:0]  crc_data;
    logic [31:0] crc_upd;
    logic [7:0]  count_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // payload bytes go into the CRC; at the frame end the command byte closes it
    assign crc_data  = (phase_reg == PH_DATA) ? in_byte_reg : command_reg;
    assign count_inc = count_reg + 8'd1;

    sfdc_crc8 u_crc8 (
        .crc_in  (crc_reg),
        .data_in (crc_data),
        .crc_out (crc_upd)
    );

    always_comb begin
        phase_next     = phase_reg;
        command_next   = command_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;
        emit           = 1'b0;
        out_kind_next  = KIND_PAYLOAD;
        out_value_next = 8'd0;
        out_index_next = 8'd0;
        out_cmd_next   = command_reg;
        out_len_next   = length_reg;

        unique case (phase_reg)
            PH_HUNT2: begin
                // a failed second sync byte is not retried as a first one
                phase_next = (in_byte_reg == SYNC_SECOND) ? PH_CMD : PH_HUNT1;
            end
            PH_CMD: begin
                command_next = in_byte_reg;
                crc_next     = CRC_ALL_ONES;
                phase_next   = PH_LEN;
            end
            PH_LEN: begin
                length_next = in_byte_reg;
                count_next  = 8'd0;
                rx_crc_next = 24'd0;
                phase_next  = (in_byte_reg == 8'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                crc_next       = crc_upd;
                emit           = 1'b1;
                out_value_next = in_byte_reg;
                out_index_next = count_reg;
                count_next     = count_inc;
                if (count_inc >= length_reg) begin
                    count_next  = 8'd0;
                    rx_crc_next = 24'd0;
                    phase_next  = PH_CRC;
                end
            end
            PH_CRC: begin
                rx_crc_next = {rx_crc_reg[15:0], in_byte_reg};
                count_next  = count_inc;
                if (count_inc >= 8'(CRC_BYTES)) begin
                    emit          = 1'b1;
                    out_kind_next = ((crc_upd ^ CRC_ALL_ONES) == {rx_crc_reg, in_byte_reg})
                                    ? KIND_GOOD : KIND_BAD;
                    count_next    = 8'd0;
                    crc_next      = CRC_ALL_ONES;
                    phase_next    = PH_HUNT1;
                end
            end
            default: begin
                // first sync hunt; unused codes behave the same
                phase_next = (in_byte_reg == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT1;
            command_reg   <= 8'd0;
            length_reg    <= 8'd0;
            count_reg     <= 8'd0;
            crc_reg       <= CRC_ALL_ONES;
            rx_crc_reg    <= 24'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= emit;
                phase_reg     <= phase_next;
                command_reg   <= command_next;
                length_reg    <= length_next;
                count_reg     <= count_next;
                crc_reg       <= crc_next;
                rx_crc_reg    <= rx_crc_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && emit) begin
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
            out_index_reg <= out_index_next;
            out_cmd_reg   <= out_cmd_next;
            out_len_reg   <= out_len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_len_reg, out_cmd_reg, out_index_reg, out_value_reg};

endmodule
